>>> rtl/irat_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irat_pkg
// Shared types and operation codes of the interval range assign table.
// ----------------------------------------------------------------------------
package irat_pkg;

  typedef logic [0:0] op_t;

  localparam op_t OP_ASSIGN = 1'b0;
  localparam op_t OP_LOOKUP = 1'b1;

endpackage

>>> rtl/irat_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irat_mem
// Breakpoint store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module irat_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 24
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/irat_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irat_ctrl
// Sequencer: scans the store, then shifts the tail and writes the new
// breakpoints of an assign in place.
// ----------------------------------------------------------------------------
module irat_ctrl #(
  parameter int ENTRIES    = 64,
  parameter int KEY_BITS   = 16,
  parameter int VALUE_BITS = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  irat_pkg::op_t                   op,
  input  logic [KEY_BITS-1:0]             key_lo,
  input  logic [KEY_BITS-1:0]             key_hi,
  input  logic [VALUE_BITS-1:0]           new_value,
  input  logic [VALUE_BITS-1:0]           default_value,
  output logic                            busy,
  output logic                            done,
  output logic [VALUE_BITS-1:0]           value_out,
  output logic                            overflow,
  output logic [$clog2(ENTRIES+1)-1:0]    used_entries,
  output logic                            mem_we,
  output logic [$clog2(ENTRIES)-1:0]      mem_waddr,
  output logic [KEY_BITS+VALUE_BITS-1:0]  mem_wdata,
  output logic [$clog2(ENTRIES)-1:0]      mem_raddr,
  input  logic [KEY_BITS+VALUE_BITS-1:0]  mem_rdata
);
  import irat_pkg::*;

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES+1);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN    = 3'd1;
  localparam logic [2:0] S_DECIDE  = 3'd2;
  localparam logic [2:0] S_COPY_RD = 3'd3;
  localparam logic [2:0] S_COPY_WR = 3'd4;
  localparam logic [2:0] S_WR_LO   = 3'd5;
  localparam logic [2:0] S_WR_HI   = 3'd6;
  localparam logic [2:0] S_FIN     = 3'd7;

  logic [2:0]            state;
  logic [CW-1:0]         cnt;
  logic [CW-1:0]         ptr;
  logic                  rv;
  logic [CW-1:0]         p;
  logic [CW-1:0]         q;
  logic [CW-1:0]         remain;
  logic [CW:0]           dst_base;
  logic                  desc;
  logic                  add_lo;
  logic                  add_hi;
  logic [CW:0]           n;
  op_t                   op_q;
  logic [KEY_BITS-1:0]   lo_q;
  logic [KEY_BITS-1:0]   hi_q;
  logic [VALUE_BITS-1:0] v_q;
  logic [VALUE_BITS-1:0] before_lo;
  logic [VALUE_BITS-1:0] at_hi;
  logic [VALUE_BITS-1:0] look;
  logic [KEY_BITS-1:0]   rkey;
  logic [VALUE_BITS-1:0] rval;
  logic                  a_c;
  logic                  b_c;
  logic [CW:0]           n_c;
  logic [CW:0]           dst_c;

  assign rkey = mem_rdata[KEY_BITS+VALUE_BITS-1:VALUE_BITS];
  assign rval = mem_rdata[VALUE_BITS-1:0];
  assign a_c  = (before_lo != v_q);
  assign b_c  = (at_hi != v_q);
  assign n_c  = {1'b0, p} + {{CW{1'b0}}, a_c} + {{CW{1'b0}}, b_c}
              + ({1'b0, cnt} - {1'b0, q});
  assign dst_c = {1'b0, ptr} + dst_base - {1'b0, q};

  assign busy         = (state != S_IDLE);
  assign done         = (state == S_FIN);
  assign used_entries = cnt;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = dst_c[AW-1:0];
    mem_wdata = mem_rdata;
    mem_raddr = ptr[AW-1:0];
    unique case (state)
      S_COPY_WR: mem_we = 1'b1;
      S_WR_LO: begin
        mem_we    = add_lo;
        mem_waddr = p[AW-1:0];
        mem_wdata = {lo_q, v_q};
      end
      S_WR_HI: begin
        mem_we    = add_hi;
        mem_waddr = AW'(p + CW'(add_lo));
        mem_wdata = {hi_q, at_hi};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      rv       <= 1'b0;
      overflow <= 1'b0;
      value_out <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op_q      <= op;
            lo_q      <= key_lo;
            hi_q      <= key_hi;
            v_q       <= new_value;
            before_lo <= default_value;
            at_hi     <= default_value;
            look      <= default_value;
            ptr       <= '0;
            rv        <= 1'b0;
            p         <= '0;
            q         <= '0;
            state     <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (rv) begin
            if (rkey < lo_q) begin
              before_lo <= rval;
              p         <= p + 1'b1;
            end
            if (rkey <= hi_q) begin
              at_hi <= rval;
              q     <= q + 1'b1;
            end
            if (rkey <= lo_q) begin
              look <= rval;
            end
          end
          if (ptr != cnt) begin
            ptr <= ptr + 1'b1;
            rv  <= 1'b1;
          end else begin
            rv <= 1'b0;
            if (!rv) begin
              state <= S_DECIDE;
            end
          end
        end
        S_DECIDE: begin
          value_out <= (op_q == OP_LOOKUP) ? look : '0;
          overflow  <= (op_q != OP_LOOKUP) && (hi_q > lo_q)
                       && (n_c > (CW+1)'(ENTRIES));
          add_lo    <= a_c;
          add_hi    <= b_c;
          n         <= n_c;
          dst_base  <= {1'b0, p} + {{CW{1'b0}}, a_c} + {{CW{1'b0}}, b_c};
          remain    <= cnt - q;
          if (op_q == OP_LOOKUP) begin
            state     <= S_FIN;
          end else if (hi_q <= lo_q) begin
            state <= S_FIN;
          end else if (n_c > (CW+1)'(ENTRIES)) begin
            state    <= S_FIN;
          end else if (cnt == q) begin
            state <= S_WR_LO;
          end else begin
            desc <= (({1'b0, p} + {{CW{1'b0}}, a_c} + {{CW{1'b0}}, b_c}) > {1'b0, q});
            if (({1'b0, p} + {{CW{1'b0}}, a_c} + {{CW{1'b0}}, b_c}) > {1'b0, q}) begin
              ptr <= cnt - 1'b1;
            end else begin
              ptr <= q;
            end
            state <= S_COPY_RD;
          end
        end
        S_COPY_RD: state <= S_COPY_WR;
        S_COPY_WR: begin
          remain <= remain - 1'b1;
          ptr    <= desc ? ptr - 1'b1 : ptr + 1'b1;
          state  <= (remain == CW'(1)) ? S_WR_LO : S_COPY_RD;
        end
        S_WR_LO: state <= S_WR_HI;
        S_WR_HI: begin
          cnt   <= n[CW-1:0];
          state <= S_FIN;
        end
        S_FIN: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/interval_range_assign_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_range_assign_table_top
// Sorted breakpoint table mapping keys to values, with range assign and
// lookup commands.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Every command gives
// one result, shown for a single cycle with done high; the receiver cannot
// stall it. Each command first scans the table through the memory's read
// port. A lookup or a refused or empty assign then goes on to decide and
// finish; an assign that goes through decides, moves each breakpoint above
// key_hi (read, write back), writes the new edges and finishes, and busy
// then falls in the idle state, where the next command is taken.
// ----------------------------------------------------------------------------
module interval_range_assign_table_top #(
  parameter int ENTRIES    = 64,
  parameter int KEY_BITS   = 16,
  parameter int VALUE_BITS = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  irat_pkg::op_t                op,
  input  logic [KEY_BITS-1:0]          key_lo,
  input  logic [KEY_BITS-1:0]          key_hi,
  input  logic [VALUE_BITS-1:0]        new_value,
  output logic                         done,
  output logic [VALUE_BITS-1:0]        value_out,
  output logic                         overflow,
  output logic [$clog2(ENTRIES+1)-1:0] used_entries,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [VALUE_BITS-1:0]        cfg_data
);
  import irat_pkg::*;

  localparam int AW = $clog2(ENTRIES);
  localparam int MW = KEY_BITS + VALUE_BITS;

  logic [VALUE_BITS-1:0] default_value;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [MW-1:0]         mem_wdata;
  logic [AW-1:0]         mem_raddr;
  logic [MW-1:0]         mem_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_value <= '0;
    end else if (cfg_valid && cfg_ready) begin
      default_value <= cfg_data;
    end
  end

  irat_mem #(
    .DEPTH (ENTRIES),
    .WIDTH (MW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  irat_ctrl #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .op            (op),
    .key_lo        (key_lo),
    .key_hi        (key_hi),
    .new_value     (new_value),
    .default_value (default_value),
    .busy          (busy),
    .done          (done),
    .value_out     (value_out),
    .overflow      (overflow),
    .used_entries  (used_entries),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_wdata     (mem_wdata),
    .mem_raddr     (mem_raddr),
    .mem_rdata     (mem_rdata)
  );

endmodule
